// File: src/rdq_pkg.sv
// Package for the reversible deque: capacity, derived widths, and action and status codes.
// Has no dependencies. The interfaces and the top level refer to it by scoped names.
package rdq_pkg;

    // Ring store size and the widths that follow from it.
    localparam int CAPACITY = 1024;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Command codes carried in the action field.
    typedef enum logic [2:0] {
        ACT_POP_BACK   = 3'd0,
        ACT_POP_FRONT  = 3'd1,
        ACT_REVERSE    = 3'd2,
        ACT_PUSH_BACK  = 3'd3,
        ACT_PUSH_FRONT = 3'd4
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// File: src/rdq_if.sv
// Valid/ready stream interfaces for the reversible deque command and result channels.
// Depends on rdq_pkg for the data width.
interface rdq_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        action;
    logic signed [rdq_pkg::DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface rdq_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [rdq_pkg::DATA_W-1:0] popped_value;
    logic [1:0]                        status;

    modport source (output valid, output popped_value, output status, input ready);
    modport sink   (input valid, input popped_value, input status, output ready);
endinterface

// File: src/reversible_deque.sv
// Top level of the reversible deque: ring store, end pointers, orientation flag, result pipeline.
// Depends on rdq_pkg and the stream interfaces in rdq_if.sv.
//
//   Channel  | Dir | Payload                      | Transfer when
//   i_cmd    | in  | action[2:0], value[31:0]     | i_cmd.valid && i_cmd.ready
//   o_res    | out | popped_value[31:0], status   | o_res.valid && o_res.ready
//
// One command is taken per cycle while i_cmd.ready is high. A result passes through
// the registered read of the ring store and then the output register.
// Pushes and reverses that succeed give no result and finish in the cycle they are taken.
// Reset is synchronous and active low; it empties the queue and clears the orientation.
// The ring store itself is not cleared, so no clearing pass is needed after reset.
// i_cmd.ready drops only while both the read stage and the output register hold results
// and o_res.ready is low.
module reversible_deque (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rdq_cmd_if.sink      i_cmd,
    rdq_res_if.source    o_res
);

    localparam int IDX_W  = rdq_pkg::IDX_W;
    localparam int CNT_W  = rdq_pkg::CNT_W;
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = rdq_pkg::DATA_W;
    localparam logic [SUM_W-1:0] CAP_S = SUM_W'(rdq_pkg::CAPACITY);

    // Ring store.
    logic [DATA_W-1:0] r_mem [rdq_pkg::CAPACITY];

    // Queue state.
    logic [IDX_W-1:0] r_first, n_first;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rev, n_rev;

    // Read stage and output register.
    logic              r_s1_valid, n_s1_valid;
    rdq_pkg::t_status  r_s1_status, n_s1_status;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_o_valid, n_o_valid;
    rdq_pkg::t_status  r_o_status;
    logic [DATA_W-1:0] r_o_value;

    logic             accept;
    logic             s1_move;
    logic             is_empty;
    logic             is_full;
    logic             at_begin;
    logic             do_write;
    logic             do_read;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] first_dec;
    logic [IDX_W-1:0] first_inc;
    logic [IDX_W-1:0] end_slot;
    logic [IDX_W-1:0] last_slot;
    logic [SUM_W-1:0] sum_end;
    logic [SUM_W-1:0] sum_last;
    rdq_pkg::t_action act;

    // Handshake: the read stage may take a new result when it is empty or moving on.
    assign s1_move     = r_s1_valid && (!r_o_valid || o_res.ready);
    assign i_cmd.ready = !r_s1_valid || s1_move;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign act         = rdq_pkg::t_action'(i_cmd.action);

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= CNT_W'(rdq_pkg::CAPACITY));

    // Ring slot arithmetic; sum_end stays below twice the capacity.
    assign first_dec = (r_first == '0) ? IDX_W'(rdq_pkg::CAPACITY - 1) : r_first - 1'b1;
    assign first_inc = (SUM_W'(r_first) + 1'b1 >= CAP_S) ? '0 : r_first + 1'b1;
    assign sum_end   = SUM_W'(r_first) + SUM_W'(r_count);
    assign end_slot  = (sum_end >= CAP_S) ? IDX_W'(sum_end - CAP_S) : sum_end[IDX_W-1:0];
    assign sum_last  = sum_end - 1'b1;
    assign last_slot = (sum_last >= CAP_S) ? IDX_W'(sum_last - CAP_S) : sum_last[IDX_W-1:0];

    // Command decode and next state of the queue.
    always_comb begin
        n_first     = r_first;
        n_count     = r_count;
        n_rev       = r_rev;
        n_s1_status = r_s1_status;
        do_write    = 1'b0;
        do_read     = 1'b0;
        at_begin    = 1'b0;
        wr_addr     = end_slot;
        rd_addr     = last_slot;
        n_s1_valid  = s1_move ? 1'b0 : r_s1_valid;
        if (accept) begin
            case (act)
                rdq_pkg::ACT_POP_BACK, rdq_pkg::ACT_POP_FRONT: begin
                    // Back is the physical beginning unless reversed.
                    at_begin   = (act == rdq_pkg::ACT_POP_BACK) ? !r_rev : r_rev;
                    n_s1_valid = 1'b1;
                    if (is_empty) begin
                        n_s1_status = rdq_pkg::ST_EMPTY;
                    end else begin
                        n_s1_status = rdq_pkg::ST_OK;
                        do_read     = 1'b1;
                        rd_addr     = at_begin ? r_first : last_slot;
                        n_first     = at_begin ? first_inc : r_first;
                        n_count     = r_count - 1'b1;
                    end
                end
                rdq_pkg::ACT_REVERSE: begin
                    n_rev = !r_rev;
                end
                rdq_pkg::ACT_PUSH_BACK, rdq_pkg::ACT_PUSH_FRONT: begin
                    at_begin = (act == rdq_pkg::ACT_PUSH_BACK) ? !r_rev : r_rev;
                    if (is_full) begin
                        n_s1_valid  = 1'b1;
                        n_s1_status = rdq_pkg::ST_FULL;
                    end else begin
                        do_write = 1'b1;
                        wr_addr  = at_begin ? first_dec : end_slot;
                        n_first  = at_begin ? first_dec : r_first;
                        n_count  = r_count + 1'b1;
                    end
                end
                default: begin
                    // Unused codes leave everything as it is.
                end
            endcase
        end
    end

    // Output register takes the read stage when it moves; otherwise it drains.
    always_comb begin
        n_o_valid = r_o_valid && !o_res.ready;
        if (s1_move) begin
            n_o_valid = 1'b1;
        end
    end

    // Ring store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[wr_addr] <= i_cmd.value;
        end
        if (do_read) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= '0;
            r_count    <= '0;
            r_rev      <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_first    <= n_first;
            r_count    <= n_count;
            r_rev      <= n_rev;
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload registers; the value is forced to zero unless the pop succeeded.
    always_ff @(posedge i_clk) begin
        r_s1_status <= n_s1_status;
        if (s1_move) begin
            r_o_status <= r_s1_status;
            r_o_value  <= (r_s1_status == rdq_pkg::ST_OK) ? r_rd_data : '0;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.popped_value = r_o_value;
    assign o_res.status       = r_o_status;

`ifndef SYNTH
    // The fill level never passes the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(rdq_pkg::CAPACITY))
        else $error("entry count above capacity");

    // A pop on an empty queue leaves a pending empty status in the read stage.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_empty &&
         (act == rdq_pkg::ACT_POP_BACK || act == rdq_pkg::ACT_POP_FRONT))
        |=> (r_s1_valid && r_s1_status == rdq_pkg::ST_EMPTY))
        else $error("empty pop did not produce an empty status");

    // A blocked read stage keeps its result.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !o_res.ready)
        |=> (r_s1_valid && $stable(r_s1_status)))
        else $error("stalled read stage lost its result");

    // Commands are refused only when both result slots are full and stalled.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ready |-> (r_s1_valid && r_o_valid && !o_res.ready))
        else $error("command channel stalled without cause");
`endif

endmodule
